>>> src/hidkb_pkg.sv
`default_nettype none

package hidkb_pkg;

    // Slot storage in the report, fixed by the boot-protocol format
    localparam int MAX_SLOTS = 6;
    localparam int KEY_SLOTS_DEF = 6;

    localparam int CODE_W = 8;
    localparam int MODE_W = 2;

    localparam logic [MODE_W-1:0] MODE_PRESS   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd2;

    localparam logic [CODE_W-1:0] MOD_MASK     = 8'hF8;
    localparam logic [CODE_W-1:0] MOD_BASE     = 8'hE0;
    localparam logic [CODE_W-1:0] MOD_BIT_MASK = 8'h07;
    localparam logic [CODE_W-1:0] EMPTY_CODE   = 8'h00;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CODE_W-1:0] keycode;
    } evt_beat_t;

    typedef struct packed {
        logic [CODE_W-1:0] modifiers;
        logic [CODE_W-1:0] key_slot_0;
        logic [CODE_W-1:0] key_slot_1;
        logic [CODE_W-1:0] key_slot_2;
        logic [CODE_W-1:0] key_slot_3;
        logic [CODE_W-1:0] key_slot_4;
        logic [CODE_W-1:0] key_slot_5;
    } rpt_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

endpackage

`default_nettype wire

>>> src/hid_keyboard_report_builder_top.sv
`default_nettype none

// Boot-protocol keyboard report builder, six-key rollover.
// Event channel (evt_valid / evt_stall / evt): one beat per key event,
//   mode = press, release or clear, keycode = HID usage. Codes 0xE0-0xE7
//   set or clear bits of the modifier byte, other codes live in packed slots.
// Report channel (rpt_valid / rpt_stall / rpt): one beat with the modifier
//   byte and all six slots, sent only when an event changed the report,
//   always on clear, and on a press of code zero while a slot is free.
// Timing: evt_stall is low only while the sequencer is idle. A modifier
//   event that changes nothing, or an unused mode, ends in the idle state.
//   Modifier changes and clear go from accept to loading the report register.
//   Key press/release runs the single slot comparator over one slot per
//   cycle, plus the load step when something changed. The report beat is
//   valid from the edge that ends the load step.
// Stall: the report register holds its beat while rpt_stall is high; the
//   sequencer keeps taking events behind it and only waits in its emit
//   step if a second report is ready before the first is taken.
// Reset: modifiers and all slots clear to zero, no report is pending.
module hid_keyboard_report_builder_top
    import hidkb_pkg::*;
#(
    parameter int KEY_SLOTS = KEY_SLOTS_DEF   // 1 to 6
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      evt_valid,
    output      logic      evt_stall,
    input  wire evt_beat_t evt,
    output      logic      rpt_valid,
    input  wire logic      rpt_stall,
    output      rpt_beat_t rpt
);

    localparam int IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEY_SLOTS - 1);

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                found_reg, found_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic [CODE_W-1:0]   mods_reg, mods_next;
    logic [CODE_W-1:0]   slot_reg [KEY_SLOTS];
    logic [CODE_W-1:0]   slot_next [KEY_SLOTS];
    logic                rpt_valid_reg, rpt_valid_next;
    rpt_beat_t           rpt_reg, rpt_next;

    // report view, slots past KEY_SLOTS read as empty
    logic [CODE_W-1:0]   view [MAX_SLOTS];
    rpt_beat_t           report_view;

    // shared slot compare unit
    logic [CODE_W-1:0]   cur;
    logic                hit_code;
    logic                hit_empty;
    logic                at_last;
    logic [IDX_W-1:0]    idx_prev;

    // modifier decode of incoming code
    logic                evt_is_mod;
    logic [CODE_W-1:0]   evt_mod_bit;

    for (genvar g = 0; g < MAX_SLOTS; g++)
    begin : g_view
        if (g < KEY_SLOTS)
        begin : g_used
            assign view[g] = slot_reg[g];
        end
        else
        begin : g_unused
            assign view[g] = EMPTY_CODE;
        end
    end

    assign report_view.modifiers  = mods_reg;
    assign report_view.key_slot_0 = view[0];
    assign report_view.key_slot_1 = view[1];
    assign report_view.key_slot_2 = view[2];
    assign report_view.key_slot_3 = view[3];
    assign report_view.key_slot_4 = view[4];
    assign report_view.key_slot_5 = view[5];

    assign cur       = slot_reg[idx_reg];
    assign hit_code  = (cur == code_reg);
    assign hit_empty = (cur == EMPTY_CODE);
    assign at_last   = (idx_reg == LAST_IDX);
    assign idx_prev  = idx_reg - 1'b1;

    assign evt_is_mod  = ((evt.keycode & MOD_MASK) == MOD_BASE);
    assign evt_mod_bit = 8'b1 << (evt.keycode & MOD_BIT_MASK);

    assign evt_stall = (state_reg != ST_IDLE);
    assign rpt_valid = rpt_valid_reg;
    assign rpt       = rpt_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        mode_next      = mode_reg;
        code_next      = code_reg;
        mods_next      = mods_reg;
        slot_next      = slot_reg;
        rpt_valid_next = rpt_valid_reg;
        rpt_next       = rpt_reg;

        if (rpt_valid_reg && !rpt_stall)
        begin
            rpt_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (evt_valid)
                begin
                    mode_next  = evt.mode;
                    code_next  = evt.keycode;
                    idx_next   = '0;
                    found_next = 1'b0;
                    case (evt.mode)
                        MODE_PRESS:
                        begin
                            if (!evt_is_mod)
                            begin
                                state_next = ST_SCAN;
                            end
                            else if ((mods_reg & evt_mod_bit) == '0)
                            begin
                                mods_next  = mods_reg | evt_mod_bit;
                                state_next = ST_EMIT;
                            end
                        end
                        MODE_RELEASE:
                        begin
                            if (!evt_is_mod)
                            begin
                                state_next = ST_SCAN;
                            end
                            else if ((mods_reg & evt_mod_bit) != '0)
                            begin
                                mods_next  = mods_reg & ~evt_mod_bit;
                                state_next = ST_EMIT;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            mods_next = '0;
                            for (int i = 0; i < KEY_SLOTS; i++)
                            begin
                                slot_next[i] = EMPTY_CODE;
                            end
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (mode_reg == MODE_PRESS)
                begin
                    // first empty slot takes the key; a match means already held
                    if (hit_empty)
                    begin
                        slot_next[idx_reg] = code_reg;
                        state_next         = ST_EMIT;
                    end
                    else if (hit_code || at_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    // release: clear the match, then slide later keys down
                    if (hit_empty)
                    begin
                        state_next = found_reg ? ST_EMIT : ST_IDLE;
                    end
                    else
                    begin
                        if (found_reg)
                        begin
                            slot_next[idx_prev] = cur;
                            slot_next[idx_reg]  = EMPTY_CODE;
                        end
                        else if (hit_code)
                        begin
                            found_next         = 1'b1;
                            slot_next[idx_reg] = EMPTY_CODE;
                        end
                        if (at_last)
                        begin
                            state_next = (found_reg || hit_code) ? ST_EMIT : ST_IDLE;
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                end
            end

            ST_EMIT:
            begin
                if (!rpt_valid_reg || !rpt_stall)
                begin
                    rpt_valid_next = 1'b1;
                    rpt_next       = report_view;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            mode_reg      <= MODE_PRESS;
            code_reg      <= EMPTY_CODE;
            mods_reg      <= '0;
            rpt_valid_reg <= 1'b0;
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                slot_reg[i] <= EMPTY_CODE;
            end
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            found_reg     <= found_next;
            mode_reg      <= mode_next;
            code_reg      <= code_next;
            mods_reg      <= mods_next;
            rpt_valid_reg <= rpt_valid_next;
            slot_reg      <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rpt_reg <= rpt_next;
    end

    // table invariants; packing and uniqueness checked whenever the sequencer rests
    logic slots_gap;
    logic slots_dup;
    logic slots_mod;

    always_comb
    begin
        slots_gap = 1'b0;
        slots_dup = 1'b0;
        slots_mod = 1'b0;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            if ((slot_reg[i] & MOD_MASK) == MOD_BASE)
            begin
                slots_mod = 1'b1;
            end
            for (int j = i + 1; j < KEY_SLOTS; j++)
            begin
                if (slot_reg[i] == EMPTY_CODE && slot_reg[j] != EMPTY_CODE)
                begin
                    slots_gap = 1'b1;
                end
                if (slot_reg[i] != EMPTY_CODE && slot_reg[i] == slot_reg[j])
                begin
                    slots_dup = 1'b1;
                end
            end
        end
    end

    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !slots_gap)
        else $error("key slots not packed");

    a_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !slots_dup)
        else $error("key held in two slots");

    a_no_mod_in_slots: assert property (@(posedge clk) disable iff (!rst_n)
        !slots_mod)
        else $error("modifier code stored in key slot");

    a_found_release: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (mode_reg == MODE_RELEASE))
        else $error("release match flag set outside release");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && !(rpt_valid_reg && rpt_stall)) |=> rpt_valid_reg)
        else $error("emit step did not load report");

endmodule

`default_nettype wire
